@@ rtl/core/pss_pkg.sv @@
package pss_pkg;

   localparam int unsigned ADDR_W    = 48;
   localparam int unsigned TIME_W    = 32;
   localparam int unsigned CAP_W     = 8;
   localparam int unsigned CSR_IDX_W = 1;
   localparam int unsigned BURST_MAX = 3;

   localparam logic [TIME_W-1:0] TIMEOUT_RESET_MS = 32'd12000;
   localparam logic [TIME_W-1:0] RESEND_RESET_MS  = 32'd750;
   localparam logic [CAP_W-1:0]  DEFAULT_CAP      = 8'd3;
   localparam logic [CAP_W-1:0]  MIN_COMPAT_CAP   = 8'd4;

   typedef enum logic [1:0] {
      OP_START  = 2'd0,
      OP_PACKET = 2'd1,
      OP_TICK   = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      PKT_HELLO   = 3'd0,
      PKT_STATS   = 3'd1,
      PKT_ACK     = 3'd2,
      PKT_NAME    = 3'd3,
      PKT_INVALID = 3'd4
   } pkt_type;

   typedef enum logic [2:0] {
      PH_IDLE     = 3'd0,
      PH_SYNCING  = 3'd1,
      PH_SYNCED   = 3'd2,
      PH_MISMATCH = 3'd3,
      PH_STORAGE  = 3'd4,
      PH_TIMEOUT  = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      KIND_NAME  = 2'd0,
      KIND_STATS = 2'd1,
      KIND_ACK   = 2'd2
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TIMEOUT = 1'd0,
      CSR_RESEND  = 1'd1
   } csr_idx_type;

   typedef struct packed {
      op_type              operation;
      logic [TIME_W-1:0]   now_ms;
      pkt_type             packet_type;
      logic [CAP_W-1:0]    peer_capability;
      logic [ADDR_W-1:0]   device_address;
      logic [ADDR_W-1:0]   sender_address;
      logic [7:0]          stats_version;
      logic                publish_ok;
      logic                queue_ok;
   } item_type;

   typedef struct packed {
      phase_type           session_phase;
      logic                peer_known;
      logic                stats_queued;
      logic                peer_acked;
      logic                stats_saved;
      logic                peer_too_old;
      logic [CAP_W-1:0]    agreed_capability;
      logic [ADDR_W-1:0]   peer_device_address;
      logic [ADDR_W-1:0]   peer_sender_address;
      logic [TIME_W-1:0]   start_time;
      logic [TIME_W-1:0]   last_send_time;
   } state_type;

   // Send requests raised by one item, in order, and the phase left behind.
   typedef struct packed {
      kind_type [BURST_MAX-1:0] kinds;
      logic [1:0]               count;
      phase_type                phase;
   } burst_type;

   typedef struct packed {
      logic [TIME_W-1:0] session_timeout_ms;
      logic [TIME_W-1:0] resend_interval_ms;
   } cfg_type;

endpackage

@@ rtl/core/pss_ifs.sv @@
interface pss_req_if import pss_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [1:0]          operation;
   logic [TIME_W-1:0]   now_ms;
   logic [2:0]          packet_type;
   logic [CAP_W-1:0]    peer_capability;
   logic [ADDR_W-1:0]   device_address;
   logic [ADDR_W-1:0]   sender_address;
   logic [7:0]          stats_version;
   logic                publish_ok;
   logic                queue_ok;

   modport source (
      output valid, operation, now_ms, packet_type, peer_capability,
             device_address, sender_address, stats_version, publish_ok, queue_ok,
      input  ready
   );
   modport sink (
      input  valid, operation, now_ms, packet_type, peer_capability,
             device_address, sender_address, stats_version, publish_ok, queue_ok,
      output ready
   );
endinterface

interface pss_rsp_if;
   logic       valid;
   logic       ready;
   logic       send_valid;
   logic [1:0] send_kind;
   logic [2:0] session_state;
   logic       last_of_run;

   modport source (
      output valid, send_valid, send_kind, session_state, last_of_run,
      input  ready
   );
   modport sink (
      input  valid, send_valid, send_kind, session_state, last_of_run,
      output ready
   );
endinterface

interface pss_csr_if import pss_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [TIME_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/peer_stats_sync_session_unit.sv @@
// Peer statistics session controller. Each request word is a start, a decoded received
// packet or a time tick, stamped with the current millisecond time; each one yields one to
// three response words, one per NAME, STATS or ACK send it asks for, or a single word with
// send_valid low when nothing is to be sent. Every response word carries the session state
// as it stands after the whole request, and last_of_run marks the final word of a request.
// A request is registered in the input register on acceptance and evaluated against the
// session state once the response register is free or giving up its last word; its words
// are then loaded into the response register, which presents the first of them. The
// response side moves one word per clock while rsp ready is high, so a request holds the
// response register for one word per send it raises (one word when none). The next
// request can be accepted into the input register while the previous one is still being
// sent. The timeout and resend intervals are written through the CSR channel, index 0
// and 1; they should be changed only while no request is in flight.
module peer_stats_sync_session_unit import pss_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   pss_req_if.sink     req_port,
   pss_rsp_if.source   rsp_port,
   pss_csr_if.sink     csr_port
);

   item_type   item_ff;
   logic       in_valid_ff;
   logic       can_load;
   logic       step_fire;
   burst_type  burst;
   cfg_type    cfg_ff;

   // The input register is refilled whenever its word moves on to the evaluation step,
   // so a word can be accepted in every cycle the response register has room.
   assign step_fire      = in_valid_ff && can_load;
   assign req_port.ready = !in_valid_ff || step_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_port.ready) begin
         in_valid_ff <= req_port.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_port.valid && req_port.ready) begin
         item_ff.operation       <= op_type'(req_port.operation);
         item_ff.now_ms          <= req_port.now_ms;
         item_ff.packet_type     <= pkt_type'(req_port.packet_type);
         item_ff.peer_capability <= req_port.peer_capability;
         item_ff.device_address  <= req_port.device_address;
         item_ff.sender_address  <= req_port.sender_address;
         item_ff.stats_version   <= req_port.stats_version;
         item_ff.publish_ok      <= req_port.publish_ok;
         item_ff.queue_ok        <= req_port.queue_ok;
      end
   end

   // Configuration registers; writes are always taken.
   assign csr_port.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.session_timeout_ms <= TIMEOUT_RESET_MS;
         cfg_ff.resend_interval_ms <= RESEND_RESET_MS;
      end else if (csr_port.valid) begin
         case (csr_idx_type'(csr_port.index))
            CSR_TIMEOUT: cfg_ff.session_timeout_ms <= csr_port.data;
            CSR_RESEND:  cfg_ff.resend_interval_ms <= csr_port.data;
            default:     cfg_ff <= cfg_ff;
         endcase
      end
   end

   pss_session u_session (
      .clock     (clock),
      .reset     (reset),
      .step_fire (step_fire),
      .item      (item_ff),
      .cfg       (cfg_ff),
      .burst     (burst)
   );

   pss_emit u_emit (
      .clock    (clock),
      .reset    (reset),
      .load     (step_fire),
      .burst    (burst),
      .can_load (can_load),
      .rsp      (rsp_port)
   );

endmodule

@@ rtl/core/pss_session.sv @@
module pss_session import pss_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      step_fire,
   input  item_type  item,
   input  cfg_type   cfg,
   output burst_type burst
);

   typedef struct packed {
      state_type st;
      burst_type br;
   } work_type;

   state_type state_ff, state_in;

   function automatic burst_type push(burst_type b, kind_type k);
      burst_type r;
      r = b;
      if (r.count < 2'(BURST_MAX)) begin
         r.kinds[r.count] = k;
         r.count = r.count + 2'd1;
      end
      return r;
   endfunction

   // Stats go out only once the peer is known and new enough.
   function automatic work_type offer(work_type w, logic [TIME_W-1:0] now, logic qok);
      work_type r;
      r = w;
      r.st.last_send_time = now;
      if (r.st.peer_known && !r.st.peer_too_old) begin
         r.br = push(r.br, KIND_NAME);
         r.br = push(r.br, KIND_STATS);
         if (qok) r.st.stats_queued = 1'b1;
      end
      return r;
   endfunction

   function automatic logic terminal(phase_type p);
      return p != PH_IDLE && p != PH_SYNCING;
   endfunction

   always_comb begin
      work_type          w;
      logic [CAP_W-1:0]  agreed_v;
      logic [CAP_W-1:0]  max_v;
      logic              stop_v;
      logic              same_peer;

      w.st       = state_ff;
      w.br       = '0;
      agreed_v   = '0;
      max_v      = '0;
      stop_v     = 1'b0;
      same_peer  = item.device_address == state_ff.peer_device_address &&
                   item.sender_address == state_ff.peer_sender_address;

      case (item.operation)
         OP_START: begin
            w.st = '0;
            w.st.start_time     = item.now_ms;
            w.st.last_send_time = item.now_ms;
         end
         OP_PACKET: begin
            if (item.packet_type <= PKT_INVALID && item.device_address != '0 &&
                item.sender_address != '0) begin
               if (terminal(state_ff.session_phase)) begin
                  // A late stats retry after sync is acknowledged again.
                  if (state_ff.session_phase == PH_SYNCED && item.packet_type == PKT_STATS &&
                      same_peer && item.publish_ok &&
                      (item.peer_capability == '0 ||
                       item.peer_capability == state_ff.agreed_capability))
                     w.br = push(w.br, KIND_ACK);
               end else if (item.packet_type == PKT_ACK &&
                            (!state_ff.peer_known || !state_ff.stats_queued)) begin
                  w.st = state_ff;
               end else if (state_ff.peer_known && !same_peer) begin
                  w.st = state_ff;
               end else begin
                  if (!state_ff.peer_known) begin
                     w.st.peer_known          = 1'b1;
                     w.st.peer_device_address = item.device_address;
                     w.st.peer_sender_address = item.sender_address;
                     w.st.session_phase       = PH_SYNCING;
                  end
                  if (item.peer_capability != '0 && state_ff.agreed_capability != '0 &&
                      state_ff.agreed_capability != item.peer_capability) begin
                     w.st.peer_acked    = 1'b0;
                     w.st.session_phase = PH_MISMATCH;
                  end else begin
                     agreed_v = (item.peer_capability != '0) ? item.peer_capability
                                                             : state_ff.agreed_capability;
                     w.st.agreed_capability = agreed_v;
                     max_v = (agreed_v != '0) ? agreed_v : DEFAULT_CAP;
                     w.st.peer_too_old = max_v < MIN_COMPAT_CAP;
                     if (item.packet_type == PKT_INVALID ||
                         (item.packet_type == PKT_STATS && item.stats_version > max_v)) begin
                        w.st.peer_acked    = 1'b0;
                        w.st.session_phase = PH_MISMATCH;
                     end else begin
                        if (item.packet_type == PKT_ACK && !w.st.peer_too_old)
                           w.st.peer_acked = 1'b1;
                        if (item.packet_type == PKT_HELLO) begin
                           w.br = push(w.br, KIND_NAME);
                           w = offer(w, item.now_ms, item.queue_ok);
                        end
                        if (item.packet_type == PKT_STATS) begin
                           if (!item.publish_ok) begin
                              w.st.peer_acked    = 1'b0;
                              w.st.session_phase = PH_STORAGE;
                              stop_v = 1'b1;
                           end else begin
                              w.st.stats_saved = 1'b1;
                              w.br = push(w.br, KIND_ACK);
                              if (w.st.peer_too_old) begin
                                 w.st.session_phase = PH_MISMATCH;
                                 stop_v = 1'b1;
                              end else if (!w.st.stats_queued) begin
                                 w = offer(w, item.now_ms, item.queue_ok);
                              end
                           end
                        end
                        if (!stop_v && w.st.stats_saved && w.st.peer_acked &&
                            !w.st.peer_too_old)
                           w.st.session_phase = PH_SYNCED;
                     end
                  end
               end
            end
         end
         OP_TICK: begin
            if (!terminal(state_ff.session_phase)) begin
               if (item.now_ms - state_ff.start_time > cfg.session_timeout_ms) begin
                  w.st.peer_acked    = 1'b0;
                  w.st.session_phase = PH_TIMEOUT;
               end else if (state_ff.peer_known && !state_ff.peer_acked &&
                            item.now_ms - state_ff.last_send_time >=
                            cfg.resend_interval_ms) begin
                  w = offer(w, item.now_ms, item.queue_ok);
               end
            end
         end
         default: begin
            w.st = state_ff;
         end
      endcase

      state_in       = w.st;
      burst          = w.br;
      burst.phase    = w.st.session_phase;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (step_fire) begin
         state_ff <= state_in;
      end
   end

   // Only a start leaves a finished session.
   a_terminal_holds: assert property (@(posedge clock) disable iff (reset)
      (step_fire && item.operation != OP_START && terminal(state_ff.session_phase))
      |=> $stable(state_ff.session_phase))
      else $error("finished session changed phase without a start");

   // Once latched, the peer addresses change only through a start.
   a_peer_latched: assert property (@(posedge clock) disable iff (reset)
      (step_fire && item.operation != OP_START && state_ff.peer_known)
      |=> ($stable(state_ff.peer_device_address) && $stable(state_ff.peer_sender_address)))
      else $error("latched peer address was overwritten");

endmodule

@@ rtl/core/pss_emit.sv @@
module pss_emit import pss_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      load,
   input  burst_type burst,
   output logic      can_load,
   pss_rsp_if.source rsp
);

   burst_type  burst_ff;
   logic       res_valid_ff;
   logic [1:0] res_idx_ff, res_idx_in;
   logic [1:0] res_words;
   logic       res_last;
   logic       word_fire;

   // An item with no send still reports its state in one word.
   assign res_words = (burst_ff.count == '0) ? 2'd1 : burst_ff.count;
   assign res_last  = res_idx_ff == res_words - 2'd1;
   assign word_fire = res_valid_ff && rsp.ready;
   assign can_load  = !res_valid_ff || (word_fire && res_last);

   assign rsp.valid         = res_valid_ff;
   assign rsp.send_valid    = burst_ff.count != '0;
   assign rsp.send_kind     = burst_ff.kinds[res_idx_ff];
   assign rsp.session_state = burst_ff.phase;
   assign rsp.last_of_run   = res_last;

   always_comb begin
      res_idx_in = res_idx_ff;
      if (load) begin
         res_idx_in = '0;
      end else if (word_fire && !res_last) begin
         res_idx_in = res_idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_valid_ff <= 1'b0;
         res_idx_ff   <= '0;
      end else begin
         res_idx_ff <= res_idx_in;
         if (load) begin
            res_valid_ff <= 1'b1;
         end else if (word_fire && res_last) begin
            res_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         burst_ff <= burst;
      end
   end

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      res_valid_ff |-> (res_idx_ff < res_words))
      else $error("word index beyond the burst");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> can_load)
      else $error("burst loaded over an unfinished one");

   a_burst_advance: assert property (@(posedge clock) disable iff (reset)
      (word_fire && !res_last) |=> (res_valid_ff && res_idx_ff == $past(res_idx_ff) + 2'd1))
      else $error("burst did not move on to its next word");

endmodule
